// File: rtl/core/cscp_pkg.sv
// Package for the cubic segment current profile block.
// Holds payload and config types, the microcode ROM and the coefficient helper.
// No dependencies; every module of the block imports it.
package cscp_pkg;

   localparam int TIME_BITS   = 32;
   localparam int COEF_BITS   = 16;
   localparam int LEN_BITS    = 24;
   localparam int LANE_BITS   = 16;
   localparam int COEFS_BITS  = 4 * LANE_BITS;
   localparam int CEIL_BITS   = 16;
   localparam int DT_BITS     = 16;
   localparam int FRAC_BITS   = 16;
   localparam int S_BITS      = FRAC_BITS + 1;
   localparam int ACC_BITS    = 32;
   localparam int PROD_BITS   = ACC_BITS + S_BITS + 1;
   localparam int SUM_BITS    = PROD_BITS - FRAC_BITS + 1;
   localparam int END_BITS    = LEN_BITS + 2;
   localparam int TCMP_BITS   = (TIME_BITS > END_BITS) ? TIME_BITS : END_BITS;
   localparam int CNT_BITS    = $clog2(FRAC_BITS);
   localparam int STEP_BITS   = 4;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [CNT_BITS-1:0] CNT_INIT = CNT_BITS'(FRAC_BITS - 1);
   localparam logic [S_BITS-1:0]   S_ONE    = {1'b1, {FRAC_BITS{1'b0}}};

   typedef logic [CSR_IDX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_RAMP_UP   = 3'd0;
   localparam csr_index_type CSR_HOLD      = 3'd1;
   localparam csr_index_type CSR_RAMP_DOWN = 3'd2;
   localparam csr_index_type CSR_UP_COEF   = 3'd3;
   localparam csr_index_type CSR_DOWN_COEF = 3'd4;
   localparam csr_index_type CSR_CEILING   = 3'd5;

   typedef struct packed {
      logic [DT_BITS-1:0] time_step;
      logic               output_enabled;
      logic               charge_relay_on;
   } req_type;

   typedef struct packed {
      logic [CEIL_BITS-1:0] current_setpoint;
      logic                 wave_running;
   } rsp_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]   up_len;
      logic [LEN_BITS-1:0]   hold_len;
      logic [LEN_BITS-1:0]   down_len;
      logic [COEFS_BITS-1:0] up_coef;
      logic [COEFS_BITS-1:0] down_coef;
      logic [CEIL_BITS-1:0]  ceiling;
   } cfg_type;

   typedef enum logic [1:0] {
      SEG_UP,
      SEG_HOLD,
      SEG_DOWN
   } seg_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_CHECK,
      OP_LOAD,
      OP_DIV_STEP,
      OP_HINIT,
      OP_MUL,
      OP_ADD,
      OP_EMIT_RUN,
      OP_EMIT_IDLE
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_IDLE,
      COND_HOLD,
      COND_DIV_MORE,
      COND_HORNER_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef logic [STEP_BITS-1:0] step_type;
   localparam step_type STEP_WAIT      = 4'd0;
   localparam step_type STEP_CHECK     = 4'd1;
   localparam step_type STEP_LOAD      = 4'd2;
   localparam step_type STEP_DIV       = 4'd3;
   localparam step_type STEP_HINIT     = 4'd4;
   localparam step_type STEP_MUL       = 4'd5;
   localparam step_type STEP_ADD       = 4'd6;
   localparam step_type STEP_EMIT_RUN  = 4'd7;
   localparam step_type STEP_RET_RUN   = 4'd8;
   localparam step_type STEP_EMIT_IDLE = 4'd9;
   localparam step_type STEP_RET_IDLE  = 4'd10;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic run_go;
      logic seg_hold;
      logic div_more;
      logic horner_more;
      logic out_busy;
   } stat_type;

   // Microcode: run the op, then jump to target when cond holds, else fall through.
   function automatic ctrl_type rom_word(input step_type s);
      ctrl_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT};
      unique case (s)
         STEP_WAIT:      w = '{op: OP_ACCEPT,    cond: COND_NO_REQ,      target: STEP_WAIT};
         STEP_CHECK:     w = '{op: OP_CHECK,     cond: COND_IDLE,        target: STEP_EMIT_IDLE};
         STEP_LOAD:      w = '{op: OP_LOAD,      cond: COND_HOLD,        target: STEP_HINIT};
         STEP_DIV:       w = '{op: OP_DIV_STEP,  cond: COND_DIV_MORE,    target: STEP_DIV};
         STEP_HINIT:     w = '{op: OP_HINIT,     cond: COND_NEVER,       target: STEP_WAIT};
         STEP_MUL:       w = '{op: OP_MUL,       cond: COND_NEVER,       target: STEP_WAIT};
         STEP_ADD:       w = '{op: OP_ADD,       cond: COND_HORNER_MORE, target: STEP_MUL};
         STEP_EMIT_RUN:  w = '{op: OP_EMIT_RUN,  cond: COND_OUT_BUSY,    target: STEP_EMIT_RUN};
         STEP_RET_RUN:   w = '{op: OP_NOP,       cond: COND_ALWAYS,      target: STEP_WAIT};
         STEP_EMIT_IDLE: w = '{op: OP_EMIT_IDLE, cond: COND_OUT_BUSY,    target: STEP_EMIT_IDLE};
         STEP_RET_IDLE:  w = '{op: OP_NOP,       cond: COND_ALWAYS,      target: STEP_WAIT};
         default:        w = '{op: OP_NOP,       cond: COND_ALWAYS,      target: STEP_WAIT};
      endcase
      return w;
   endfunction

   // Take one 16-bit lane and sign-extend its low COEF_BITS bits.
   function automatic logic signed [ACC_BITS-1:0] coef_lane(
      input logic [COEFS_BITS-1:0] coefs_w,
      input logic [1:0]            lane
   );
      logic [LANE_BITS-1:0]        raw;
      logic signed [COEF_BITS-1:0] c;
      raw = coefs_w[lane*LANE_BITS +: LANE_BITS];
      c   = raw[COEF_BITS-1:0];
      return ACC_BITS'(c);
   endfunction

endpackage

// File: rtl/core/cscp_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on cscp_pkg for the ROM contents and the control and status types.
module cscp_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  cscp_pkg::stat_type stat,
   output cscp_pkg::ctrl_type ctrl,
   output logic               req_stall
);
   import cscp_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     take;

   assign ctrl      = rom_word(step_ff);
   assign req_stall = (step_ff != STEP_WAIT);

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:       take = 1'b0;
         COND_ALWAYS:      take = 1'b1;
         COND_NO_REQ:      take = !req_valid;
         COND_IDLE:        take = !stat.run_go;
         COND_HOLD:        take = stat.seg_hold;
         COND_DIV_MORE:    take = stat.div_more;
         COND_HORNER_MORE: take = stat.horner_more;
         COND_OUT_BUSY:    take = stat.out_busy;
         default:          take = 1'b1;
      endcase
      step_in = take ? ctrl.target : STEP_BITS'(step_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (step_ff == STEP_CHECK))
      else $error("accepted transfer did not advance to the check step");

endmodule

// File: rtl/core/cscp_dpath.sv
// Datapath: run control, restoring divider for s, Horner unit, clamp and result register.
// Depends on cscp_pkg; driven one op per cycle by cscp_seq.
module cscp_dpath (
   input  logic               clock,
   input  logic               reset,
   input  cscp_pkg::ctrl_type ctrl,
   input  cscp_pkg::cfg_type  cfg,
   input  cscp_pkg::req_type  req_data,
   input  logic               rsp_stall,
   output cscp_pkg::stat_type stat,
   output logic               rsp_valid,
   output cscp_pkg::rsp_type  rsp_data
);
   import cscp_pkg::*;

   // control state
   logic                 run_ff, run_in;
   logic                 last_en_ff, last_en_in;
   logic                 last_relay_ff, last_relay_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   req_type                   item_ff, item_in;
   logic [END_BITS-1:0]       down_start_ff, down_start_in;
   logic [END_BITS-1:0]       run_end_ff, run_end_in;
   logic [LEN_BITS-1:0]       dlen_ff, dlen_in;
   seg_type                   seg_ff, seg_in;
   logic [LEN_BITS-1:0]       rem_ff, rem_in;
   logic [LEN_BITS-1:0]       div_ff, div_in;
   logic [FRAC_BITS-1:0]      quo_ff, quo_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [S_BITS-1:0]         s_ff, s_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic [1:0]                lane_ff, lane_in;
   rsp_type                   rsp_ff, rsp_in;

   // combinational helpers
   logic                   en, relay, start, run_a, run_go, out_busy;
   logic [TIME_BITS-1:0]   t_chk;
   logic [TCMP_BITS-1:0]   te_chk, te_cur, trel_wide;
   logic                   in_up, in_hold, in_down;
   logic [LEN_BITS:0]      r2, r2_diff;
   logic [COEFS_BITS-1:0]  coefs;
   logic signed [S_BITS:0] s_sgn;
   logic signed [SUM_BITS-1:0] sum;
   logic [TIME_BITS:0]     tsum;
   logic [CEIL_BITS-1:0]   y;
   logic [LEN_BITS-1:0]    dlen_eff;

   assign en       = item_ff.output_enabled;
   assign relay    = item_ff.charge_relay_on;
   assign start    = en && !relay && !run_ff && (!last_en_ff || (last_relay_ff && !relay));
   assign run_a    = (start || run_ff) && en && !relay;
   assign t_chk    = start ? '0 : elapsed_ff;
   assign te_chk   = TCMP_BITS'(t_chk);
   assign in_up    = te_chk < TCMP_BITS'(cfg.up_len);
   assign in_hold  = te_chk < TCMP_BITS'(down_start_ff);
   assign in_down  = te_chk < TCMP_BITS'(run_end_ff);
   assign run_go   = run_a && in_down;
   assign out_busy = rsp_valid_ff && rsp_stall;

   assign dlen_eff  = (cfg.down_len == '0) ? LEN_BITS'(1) : cfg.down_len;
   assign te_cur    = TCMP_BITS'(elapsed_ff);
   assign trel_wide = te_cur - TCMP_BITS'(down_start_ff);
   assign r2        = {rem_ff, 1'b0};
   assign r2_diff   = r2 - {1'b0, div_ff};
   assign coefs     = (seg_ff == SEG_DOWN) ? cfg.down_coef : cfg.up_coef;
   assign s_sgn     = {1'b0, s_ff};
   assign sum       = SUM_BITS'(prod_ff >>> FRAC_BITS) + SUM_BITS'(coef_lane(coefs, lane_ff));
   assign tsum      = {1'b0, elapsed_ff} + (TIME_BITS+1)'(item_ff.time_step);

   // clamp to [0, ceiling]
   always_comb begin
      priority if (acc_ff[ACC_BITS-1]) begin
         y = '0;
      end else if (acc_ff[ACC_BITS-2:0] > (ACC_BITS-1)'(cfg.ceiling)) begin
         y = cfg.ceiling;
      end else begin
         y = acc_ff[CEIL_BITS-1:0];
      end
   end

   assign stat.run_go      = run_go;
   assign stat.seg_hold    = (seg_ff == SEG_HOLD);
   assign stat.div_more    = (cnt_ff != '0);
   assign stat.horner_more = (lane_ff != '0);
   assign stat.out_busy    = out_busy;

   always_comb begin
      run_in        = run_ff;
      last_en_in    = last_en_ff;
      last_relay_in = last_relay_ff;
      elapsed_in    = elapsed_ff;
      rsp_valid_in  = out_busy;
      item_in       = item_ff;
      down_start_in = down_start_ff;
      run_end_in    = run_end_ff;
      dlen_in       = dlen_ff;
      seg_in        = seg_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      s_in          = s_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      lane_in       = lane_ff;
      rsp_in        = rsp_ff;
      unique case (ctrl.op)
         OP_NOP: begin
         end
         OP_ACCEPT: begin
            // track the payload while waiting; segment bounds come from stable config
            item_in       = req_data;
            dlen_in       = dlen_eff;
            down_start_in = END_BITS'(cfg.up_len) + END_BITS'(cfg.hold_len);
            run_end_in    = END_BITS'(cfg.up_len) + END_BITS'(cfg.hold_len)
                            + END_BITS'(dlen_eff);
         end
         OP_CHECK: begin
            last_en_in    = en;
            last_relay_in = relay;
            run_in        = run_go;
            elapsed_in    = t_chk;
            priority if (in_up) begin
               seg_in = SEG_UP;
            end else if (in_hold) begin
               seg_in = SEG_HOLD;
            end else begin
               seg_in = SEG_DOWN;
            end
         end
         OP_LOAD: begin
            if (seg_ff == SEG_DOWN) begin
               rem_in = trel_wide[LEN_BITS-1:0];
               div_in = dlen_ff;
            end else begin
               rem_in = elapsed_ff[LEN_BITS-1:0];
               div_in = cfg.up_len;
            end
            cnt_in = CNT_INIT;
         end
         OP_DIV_STEP: begin
            // one quotient bit per step
            if (!r2_diff[LEN_BITS]) begin
               rem_in = r2_diff[LEN_BITS-1:0];
               quo_in = {quo_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               rem_in = r2[LEN_BITS-1:0];
               quo_in = {quo_ff[FRAC_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end
         OP_HINIT: begin
            s_in    = (seg_ff == SEG_HOLD) ? S_ONE : {1'b0, quo_ff};
            acc_in  = coef_lane(coefs, 2'd3);
            lane_in = 2'd2;
         end
         OP_MUL: begin
            prod_in = acc_ff * s_sgn;
         end
         OP_ADD: begin
            // floor by arithmetic shift, add lane, saturate to 32 bits
            if ((sum[SUM_BITS-1:ACC_BITS-1] == '0) || (sum[SUM_BITS-1:ACC_BITS-1] == '1)) begin
               acc_in = sum[ACC_BITS-1:0];
            end else if (sum[SUM_BITS-1]) begin
               acc_in = {1'b1, {(ACC_BITS-1){1'b0}}};
            end else begin
               acc_in = {1'b0, {(ACC_BITS-1){1'b1}}};
            end
            lane_in = lane_ff - 1'b1;
         end
         OP_EMIT_RUN: begin
            if (!out_busy) begin
               rsp_in.current_setpoint = y;
               rsp_in.wave_running     = 1'b1;
               rsp_valid_in            = 1'b1;
               elapsed_in = tsum[TIME_BITS] ? '1 : tsum[TIME_BITS-1:0];
            end
         end
         OP_EMIT_IDLE: begin
            if (!out_busy) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         last_en_ff    <= 1'b0;
         last_relay_ff <= 1'b0;
         elapsed_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         run_ff        <= run_in;
         last_en_ff    <= last_en_in;
         last_relay_ff <= last_relay_in;
         elapsed_ff    <= elapsed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      down_start_ff <= down_start_in;
      run_end_ff    <= run_end_in;
      dlen_ff       <= dlen_in;
      seg_ff        <= seg_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      s_ff          <= s_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      lane_ff       <= lane_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_emit_run: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_EMIT_RUN && !out_busy) |=> (rsp_valid_ff && rsp_ff.wave_running))
      else $error("running result not registered after emit");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.wave_running) |-> (rsp_ff.current_setpoint == '0))
      else $error("idle result carries a nonzero setpoint");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DIV_STEP) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

endmodule

// File: rtl/core/cubic_segment_current_profile_top.sv
// Flow: an accepted ramp tick runs the 16-step restoring divider for s and three
//   multiply/add Horner passes; a hold tick skips the divider; an idle or aborting tick
//   goes straight to emit. A new transfer is taken only once the step is back in wait.
// Reset (synchronous, active high): sequencer back to wait, run and edge history cleared,
//   elapsed time zero, no result pending, lengths and coefficients zero, ceiling all ones.
module cubic_segment_current_profile_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  cscp_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output cscp_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_wr_en,
   input  logic [cscp_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [cscp_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import cscp_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   ctrl_type ctrl;
   stat_type stat;

   // Config registers: write-only. Writing them only while the block is idle is up to the user.
   // Narrow registers keep the low bits of the write data; unknown indexes drop the write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RAMP_UP:   cfg_in.up_len    = csr_wdata[LEN_BITS-1:0];
            CSR_HOLD:      cfg_in.hold_len  = csr_wdata[LEN_BITS-1:0];
            CSR_RAMP_DOWN: cfg_in.down_len  = csr_wdata[LEN_BITS-1:0];
            CSR_UP_COEF:   cfg_in.up_coef   = csr_wdata[COEFS_BITS-1:0];
            CSR_DOWN_COEF: cfg_in.down_coef = csr_wdata[COEFS_BITS-1:0];
            CSR_CEILING:   cfg_in.ceiling   = csr_wdata[CEIL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_len    <= '0;
         cfg_ff.hold_len  <= '0;
         cfg_ff.down_len  <= '0;
         cfg_ff.up_coef   <= '0;
         cfg_ff.down_coef <= '0;
         cfg_ff.ceiling   <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequencer: the step counter walks the ROM program; it holds req_stall low only
   // in the wait step, so one transfer is in flight at a time.
   cscp_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .ctrl      (ctrl),
      .req_stall (req_stall)
   );

   // Datapath: check start/abort, divide for s, evaluate the cubic, clamp, and hold the
   // result in its own register so the next transfer can be accepted while it waits.
   cscp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/tb.sv
// Testbench for cubic_segment_current_profile_top: directed and random tick streams checked
// against a cycle-free model of the ramp-up, hold and ramp-down profile with random pacing.
// Depends on cscp_pkg for the transfer payload types, widths and register indexes.
module tb;
   import cscp_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 11;
   localparam int SETTLE_CYCLES   = 8;      // block is back in wait before the profile is written
   localparam int DRAIN_CYCLES    = 40;     // the ramp path through the divider is the longest
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int TIMEOUT_CYCLES  = 800000;
   localparam int SWEEP_SETTINGS  = 8;
   localparam int SWEEP_TICKS     = 140;
   localparam int MAX_REPORTS     = 10;

   localparam longint          ACC_MAX  = (longint'(1) <<< (ACC_BITS - 1)) - 1;
   localparam longint          ACC_MIN  = -(longint'(1) <<< (ACC_BITS - 1));
   localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 1;
   localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;
   localparam logic [CEIL_BITS-1:0] CEIL_MAX = '1;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BURST
   } stall_mode_type;

   // DUT inputs start at known values; later changes are nonblocking at the clock edge
   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_wr_en = 1'b0;
   csr_index_type            csr_index = CSR_RAMP_UP;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Mirror of the profile registers and of the run state
   logic [LEN_BITS-1:0]   prof_up_len;
   logic [LEN_BITS-1:0]   prof_hold_len;
   logic [LEN_BITS-1:0]   prof_down_len;
   logic [COEFS_BITS-1:0] prof_up_coef;
   logic [COEFS_BITS-1:0] prof_down_coef;
   logic [CEIL_BITS-1:0]  prof_ceiling;
   logic [TIME_BITS-1:0]  run_clock;
   logic                  run_on;
   logic                  seen_enable;
   logic                  seen_relay;

   rsp_type setpoint_q[$];          // expected setpoints, oldest first

   int  mismatches     = 0;
   int  ticks_sent     = 0;
   int  setpoints_seen = 0;
   int  settings_used  = 0;
   int  runs_armed     = 0;
   int  runs_completed = 0;
   int  runs_aborted   = 0;
   int  clamped_high   = 0;
   int  clamped_low    = 0;
   int  burst_left     = 0;
   int  longest_hold   = 0;
   bit  pace_sender    = 1'b1;
   bit  hold_off_req   = 1'b0;
   bit  burst_level    = 1'b0;

   cubic_segment_current_profile_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard limit on the whole run
   initial begin
      #(longint'(TIMEOUT_CYCLES) * CLOCK_PERIOD);
      $display("timeout after %0d cycles, %0d setpoints still outstanding",
               TIMEOUT_CYCLES, setpoint_q.size());
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Profile model
   // ---------------------------------------------------------------------------------------

   task automatic clear_mirror();
      prof_up_len    = '0;
      prof_hold_len  = '0;
      prof_down_len  = '0;
      prof_up_coef   = '0;
      prof_down_coef = '0;
      prof_ceiling   = CEIL_MAX;
      run_clock      = '0;
      run_on         = 1'b0;
      seen_enable    = 1'b0;
      seen_relay     = 1'b0;
   endtask

   // Signed coefficient held in the low COEF_BITS of a 16-bit lane
   function automatic longint lane_value(input logic [COEFS_BITS-1:0] coefs, input int k);
      logic signed [COEF_BITS-1:0] c;
      c = coefs[k*LANE_BITS +: COEF_BITS];
      return longint'(c);
   endfunction

   function automatic longint clip_acc(input longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
   endfunction

   // Horner evaluation with s in Q1.16; the arithmetic shift floors toward minus infinity
   function automatic longint eval_cubic(input logic [COEFS_BITS-1:0] coefs, input longint s);
      longint acc;
      acc = lane_value(coefs, 3);
      for (int k = 2; k >= 0; k--)
         acc = clip_acc(((acc * s) >>> FRAC_BITS) + lane_value(coefs, k));
      return acc;
   endfunction

   // Advance the run state by one tick and return the setpoint it produces
   function automatic rsp_type predict_setpoint(input req_type item);
      rsp_type         res;
      logic            relay_opened;
      longint unsigned up_len, down_len, down_start, run_end, t, frac;
      longint          y, ceil_v;
      res          = '0;
      relay_opened = seen_relay && !item.charge_relay_on;
      if (item.output_enabled && !item.charge_relay_on && !run_on &&
          (!seen_enable || relay_opened)) begin
         run_clock = '0;
         run_on    = 1'b1;
         runs_armed++;
      end
      seen_enable = item.output_enabled;
      seen_relay  = item.charge_relay_on;
      if (!item.output_enabled || item.charge_relay_on) begin
         if (run_on) runs_aborted++;
         run_on = 1'b0;
      end
      if (!run_on) return res;

      up_len     = prof_up_len;
      down_len   = (prof_down_len == 0) ? 64'd1 : 64'(prof_down_len);
      down_start = up_len + prof_hold_len;
      run_end    = down_start + down_len;
      t          = run_clock;
      if (t < up_len) begin
         frac = (t << FRAC_BITS) / up_len;
         y    = eval_cubic(prof_up_coef, longint'(frac));
      end else if (t < down_start) begin
         y = eval_cubic(prof_up_coef, longint'(1) << FRAC_BITS);
      end else if (t < run_end) begin
         frac = ((t - down_start) << FRAC_BITS) / down_len;
         y    = eval_cubic(prof_down_coef, longint'(frac));
      end else begin
         run_on = 1'b0;
         runs_completed++;
         return res;
      end

      ceil_v = prof_ceiling;
      if (y < 0) begin
         y = 0;
         clamped_low++;
      end
      if (y > ceil_v) begin
         y = ceil_v;
         clamped_high++;
      end
      res.current_setpoint = CEIL_BITS'(y);
      res.wave_running     = 1'b1;
      t = t + item.time_step;
      run_clock = TIME_BITS'((t > TIME_MAX) ? TIME_MAX : t);
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result checking: every accepted result transfer is compared with the oldest prediction
   // ---------------------------------------------------------------------------------------

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s: expected setpoint %0d running %0b, got setpoint %0d running %0b",
                  $time, what, want.current_setpoint, want.wave_running,
                  got.current_setpoint, got.wave_running);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         setpoints_seen++;
         if (setpoint_q.size() == 0) begin
            note_mismatch("result with no tick outstanding", '0, rsp_data);
         end else begin
            want = setpoint_q.pop_front();
            if (rsp_data.current_setpoint !== want.current_setpoint)
               note_mismatch("current_setpoint", want, rsp_data);
            if (rsp_data.wave_running !== want.wave_running)
               note_mismatch("wave_running", want, rsp_data);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result-side pacing: stall modes of random length, plus one long hold-off on request
   // ---------------------------------------------------------------------------------------

   initial begin : rsp_pacing
      stall_mode_type mode;
      int             mode_left;
      int             run_left;
      mode      = STALL_NONE;
      mode_left = 0;
      run_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            // Hold the result channel off so the block backs up into req_stall
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
            longest_hold = HOLD_OFF_CYCLES;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: begin
                  if (run_left == 0) begin
                     run_left    = $urandom_range(1, 12);
                     burst_level = ~burst_level;
                  end
                  run_left--;
                  rsp_stall <= burst_level;
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tick and register drivers
   // ---------------------------------------------------------------------------------------

   function automatic req_type make_tick(input logic [DT_BITS-1:0] dt, input logic en,
                                         input logic relay);
      req_type item;
      item.time_step       = dt;
      item.output_enabled  = en;
      item.charge_relay_on = relay;
      return item;
   endfunction

   // Offer one tick, hold it until the transfer, then record its predicted setpoint.
   // Between bursts, drop valid for a random gap so gaps land on every sequencer step.
   task automatic send_tick(input req_type item);
      int gap;
      if (pace_sender && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      setpoint_q.push_back(predict_setpoint(item));
      ticks_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   // Drop valid, wait for every outstanding setpoint, then let the block go quiet
   task automatic drain_results(input int extra);
      req_valid <= 1'b0;
      while (setpoint_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_RAMP_UP:   prof_up_len    = data[LEN_BITS-1:0];
         CSR_HOLD:      prof_hold_len  = data[LEN_BITS-1:0];
         CSR_RAMP_DOWN: prof_down_len  = data[LEN_BITS-1:0];
         CSR_UP_COEF:   prof_up_coef   = data[COEFS_BITS-1:0];
         CSR_DOWN_COEF: prof_down_coef = data[COEFS_BITS-1:0];
         CSR_CEILING:   prof_ceiling   = data[CEIL_BITS-1:0];
         default: ;
      endcase
   endtask

   // Place a field in the low bits of a word with random upper bits the block must ignore
   function automatic logic [CSR_DATA_BITS-1:0] with_junk(input logic [CSR_DATA_BITS-1:0] v,
                                                         input int bits);
      logic [CSR_DATA_BITS-1:0] w;
      w = {$urandom, $urandom};
      for (int b = 0; b < bits; b++) w[b] = v[b];
      return w;
   endfunction

   // Program a full profile while idle; also write one unmapped index, which must be ignored
   task automatic load_profile(input logic [LEN_BITS-1:0] up_len, hold_len, down_len,
                               input logic [COEFS_BITS-1:0] up_coef, down_coef,
                               input logic [CEIL_BITS-1:0] ceiling);
      drain_results(SETTLE_CYCLES);
      write_reg(CSR_RAMP_UP,   with_junk(up_len, LEN_BITS));
      write_reg(CSR_HOLD,      with_junk(hold_len, LEN_BITS));
      write_reg(CSR_RAMP_DOWN, with_junk(down_len, LEN_BITS));
      write_reg(CSR_UP_COEF,   up_coef);
      write_reg(CSR_DOWN_COEF, down_coef);
      write_reg(csr_index_type'($urandom_range(int'(CSR_CEILING) + 1,
                                               (1 << CSR_IDX_BITS) - 1)),
                {$urandom, $urandom});
      write_reg(CSR_CEILING,   with_junk(ceiling, CEIL_BITS));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [COEFS_BITS-1:0] pack_lanes(input int a, b, c, d);
      return {16'(d), 16'(c), 16'(b), 16'(a)};
   endfunction

   function automatic logic [COEFS_BITS-1:0] pick_coefs();
      logic [COEFS_BITS-1:0] w;
      case ($urandom_range(0, 3))
         0: w = {$urandom, $urandom};
         1: begin
            // lanes at the signed extremes, zero and minus one
            for (int k = 0; k < 4; k++)
               case ($urandom_range(0, 3))
                  0: w[k*LANE_BITS +: LANE_BITS] = 16'h8000;
                  1: w[k*LANE_BITS +: LANE_BITS] = 16'h7FFF;
                  2: w[k*LANE_BITS +: LANE_BITS] = 16'h0000;
                  default: w[k*LANE_BITS +: LANE_BITS] = 16'hFFFF;
               endcase
         end
         default: begin
            // plausible current shape: positive offset, mostly rising
            w = pack_lanes($urandom_range(0, 4000), $urandom_range(0, 20000),
                           int'($urandom_range(0, 16000)) - 8000,
                           int'($urandom_range(0, 8000)) - 4000);
         end
      endcase
      return w;
   endfunction

   function automatic logic [LEN_BITS-1:0] pick_length();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return LEN_BITS'($urandom_range(1, 4));
         2:       return LEN_BITS'($urandom_range(1000, 200000));
         default: return LEN_BITS'($urandom_range(5, 400));
      endcase
   endfunction

   function automatic logic [DT_BITS-1:0] pick_step(input int unsigned cap);
      if ($urandom_range(0, 11) == 0) return DT_BITS'($urandom);
      return DT_BITS'($urandom_range(0, cap));
   endfunction

   // One well-formed run with random content: arm it by an enable edge or a relay opening,
   // walk it with steps scaled to the profile, and now and then abort it early.
   task automatic play_run(input int max_ticks);
      longint unsigned span;
      int unsigned     dt_cap;
      int              n;
      bit              stop;
      span   = 64'(prof_up_len) + prof_hold_len + ((prof_down_len == 0) ? 1 : prof_down_len);
      dt_cap = (span / 5 + 1 > 65535) ? 65535 : int'(span / 5 + 1);
      stop   = 1'b0;
      if ($urandom_range(0, 2) == 0)
         send_tick(make_tick(pick_step(dt_cap), 1'b1, 1'b1));
      else
         send_tick(make_tick(pick_step(dt_cap), 1'b0, 1'($urandom_range(0, 1))));
      send_tick(make_tick(pick_step(dt_cap), 1'b1, 1'b0));
      n = $urandom_range(3, max_ticks);
      for (int i = 0; i < n && !stop; i++) begin
         case ($urandom_range(0, 29))
            0: begin
               send_tick(make_tick(pick_step(dt_cap), 1'b0, 1'($urandom_range(0, 1))));
               stop = 1'b1;
            end
            1: begin
               send_tick(make_tick(pick_step(dt_cap), 1'b1, 1'b1));
               stop = 1'b1;
            end
            default: send_tick(make_tick(pick_step(dt_cap), 1'b1, 1'b0));
         endcase
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Registers at reset: zero lengths, so the run is a single one-tick ramp-down at zero
   task automatic test_reset_defaults();
      send_tick(make_tick(16'd1, 1'b1, 1'b0));
      send_tick(make_tick(16'd0, 1'b1, 1'b0));
   endtask

   // Walk one run through every segment, then the start and abort conditions
   task automatic test_directed_profile();
      load_profile(24'd100, 24'd50, 24'd0, pack_lanes(1000, 3000, -2000, 500),
                   pack_lanes(2500, -1500, -800, 200), CEIL_MAX);
      send_tick(make_tick(16'd0,     1'b0, 1'b0));   // idle
      send_tick(make_tick(16'hFFFF,  1'b1, 1'b1));   // relay closed blocks the start
      send_tick(make_tick(16'd0,     1'b1, 1'b0));   // relay opens while enabled: start
      send_tick(make_tick(16'd25,    1'b1, 1'b0));   // zero step leaves time at zero
      send_tick(make_tick(16'd100,   1'b1, 1'b0));   // mid ramp-up
      send_tick(make_tick(16'd24,    1'b1, 1'b0));   // hold
      send_tick(make_tick(16'd1,     1'b1, 1'b0));   // last hold tick
      send_tick(make_tick(16'd1,     1'b1, 1'b0));   // one-tick ramp-down for zero length
      send_tick(make_tick(16'd7,     1'b1, 1'b0));   // run complete
      send_tick(make_tick(16'd0,     1'b1, 1'b0));   // enable still high: no new run
      send_tick(make_tick(16'd0,     1'b0, 1'b0));
      send_tick(make_tick(16'd10,    1'b1, 1'b0));   // enable edge starts
      send_tick(make_tick(16'd3,     1'b1, 1'b1));   // relay closes: abort
      send_tick(make_tick(16'd3,     1'b1, 1'b0));   // relay reopens: restart
      send_tick(make_tick(16'd3,     1'b0, 1'b0));   // enable drops: abort
   endtask

   // Skipped ramp-up, clamp at the ceiling, full-scale time step
   task automatic test_clamp_and_zero_ramp();
      load_profile(24'd0, 24'd10, 24'd20, pack_lanes(30000, 30000, 0, 0),
                   pack_lanes(-5000, 0, 0, -32768), 16'd1234);
      send_tick(make_tick(16'd0,    1'b0, 1'b0));
      send_tick(make_tick(16'd5,    1'b1, 1'b0));
      send_tick(make_tick(16'hFFFF, 1'b1, 1'b0));
      send_tick(make_tick(16'd0,    1'b1, 1'b0));
   endtask

   // Every length at its maximum, walked with the largest steps
   task automatic test_longest_lengths();
      load_profile(LEN_MAX, LEN_MAX, LEN_MAX, pick_coefs(), pick_coefs(), CEIL_MAX);
      send_tick(make_tick(16'd0, 1'b0, 1'b0));
      repeat (3) send_tick(make_tick(16'hFFFF, 1'b1, 1'b0));
   endtask

   // Random profiles, the ceiling at both ends first, with sender pacing on and off
   task automatic test_register_sweep();
      logic [CEIL_BITS-1:0] ceiling;
      int                   target;
      for (int s = 0; s < SWEEP_SETTINGS; s++) begin
         if (s == 0)                           ceiling = '0;
         else if (s == 1)                      ceiling = CEIL_MAX;
         else if ($urandom_range(0, 1) == 0)   ceiling = CEIL_BITS'($urandom);
         else                                  ceiling = CEIL_BITS'($urandom_range(1000, 8000));
         load_profile(pick_length(), pick_length(), pick_length(), pick_coefs(), pick_coefs(),
                      ceiling);
         pace_sender = (s % 2 == 0);
         target = ticks_sent + SWEEP_TICKS;
         while (ticks_sent < target) play_run(14);
      end
      pace_sender = 1'b1;
   endtask

   // Hold the result channel off while ticks keep coming, so the input backs up
   task automatic test_output_holdoff();
      int target;
      load_profile(24'd40, 24'd20, 24'd40, pick_coefs(), pick_coefs(), CEIL_MAX);
      pace_sender  = 1'b0;
      hold_off_req = 1'b1;
      target = ticks_sent + 40;
      while (ticks_sent < target) play_run(10);
      pace_sender = 1'b1;
   endtask

   // Unstructured levels and full-range steps
   task automatic test_random_levels();
      load_profile(pick_length(), pick_length(), pick_length(), pick_coefs(), pick_coefs(),
                   CEIL_BITS'($urandom));
      repeat (120)
         send_tick(make_tick(DT_BITS'($urandom), 1'($urandom_range(0, 1)),
                             ($urandom_range(0, 3) == 0)));
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      clear_mirror();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_profile();
      test_clamp_and_zero_ramp();
      test_longest_lengths();
      test_register_sweep();
      test_output_holdoff();
      test_random_levels();

      drain_results(DRAIN_CYCLES);
      $display("covered %0d ticks under %0d register settings: %0d runs armed, %0d completed, %0d aborted",
               ticks_sent, settings_used, runs_armed, runs_completed, runs_aborted);
      $display("setpoints checked %0d, clamped at ceiling %0d and at zero %0d, hold-off %0d cycles",
               setpoints_seen, clamped_high, clamped_low, longest_hold);
      if (mismatches == 0 && setpoint_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d setpoints never arrived", mismatches, setpoint_q.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/cscp_pkg.sv
rtl/core/cscp_seq.sv
rtl/core/cscp_dpath.sv
rtl/core/cubic_segment_current_profile_top.sv
verif/tb.sv
